/* hw/rtl/pnc_pkg.sv */
// Package for the palette nearest-color match block.
// Holds shared widths, operation and register codes, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package pnc_pkg;

  // Default palette depth
  localparam int PALETTE_ENTRIES_DEF = 256;

  // Field and bus widths
  localparam int OP_W        = 2;
  localparam int INDEX_W     = 8;
  localparam int COMP_W      = 16;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 24;
  localparam int NATIVE_W    = 16;
  localparam int DIST_W      = 18;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 18;

  // Register reset values and fixed answers
  localparam logic [DIST_W-1:0]  MATCH_LIMIT_RESET = 18'd1024;
  localparam logic [INDEX_W-1:0] NO_MATCH_INDEX    = 8'd255;
  localparam logic [INDEX_W-1:0] REV_CLAMP_INDEX   = 8'd255;

  // Operation codes (code 3 is unused and ignored)
  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_MATCH   = 2'd1,
    OP_REVERSE = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE = 1'd0,
    REG_LIMIT  = 1'd1
  } reg_idx_t;

  // Source of the result item loaded into the output register
  typedef enum logic [1:0] {
    OUT_ZERO  = 2'd0,
    OUT_MATCH = 2'd1,
    OUT_REV   = 2'd2
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     accept;    // input item taken this cycle
    logic     clear_wr;  // clearing pass: write zero at scan address
    logic     scan_rd;   // match scan: read at scan address
    logic     sel_rev;   // read address from reverse-lookup register
    logic     cap_rev;   // capture read data as reverse color
    logic     out_load;  // load output register
    out_sel_t out_sel;
  } pnc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;   // scan address is the last entry
    logic pipe_empty;  // distance pipeline drained
    logic out_free;    // output register can take an item
    logic enabled;     // palette_enabled register
  } pnc_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/pnc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/pnc_ctrl.sv */
// Controller state machine for the palette nearest-color match block.
// Depends on pnc_pkg; drives the datapath through pnc_cmd_t and reads pnc_stat_t.
`default_nettype none

module pnc_ctrl
  import pnc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire op_t       op,
  input  wire pnc_stat_t stat,
  output logic           in_ready,
  output pnc_cmd_t       cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR     = 9'b0_0000_0001,
    ST_IDLE      = 9'b0_0000_0010,
    ST_SCAN      = 9'b0_0000_0100,
    ST_DRAIN     = 9'b0_0000_1000,
    ST_REV_ADDR  = 9'b0_0001_0000,
    ST_REV_DATA  = 9'b0_0010_0000,
    ST_FIN_MATCH = 9'b0_0100_0000,
    ST_FIN_REV   = 9'b0_1000_0000,
    ST_FIN_ZERO  = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.out_sel  = OUT_ZERO;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.scan_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (op)
            OP_MATCH:   state_next = stat.enabled ? ST_SCAN : ST_FIN_ZERO;
            OP_REVERSE: state_next = stat.enabled ? ST_REV_ADDR : ST_FIN_ZERO;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) state_next = ST_FIN_MATCH;
      end
      ST_REV_ADDR: begin
        cmd.sel_rev = 1'b1;
        state_next  = ST_REV_DATA;
      end
      ST_REV_DATA: begin
        cmd.cap_rev = 1'b1;
        state_next  = ST_FIN_REV;
      end
      ST_FIN_MATCH: begin
        cmd.out_sel = OUT_MATCH;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_FIN_REV: begin
        cmd.out_sel = OUT_REV;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_FIN_ZERO: begin
        cmd.out_sel = OUT_ZERO;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/pnc_dp.sv */
// Datapath for the palette nearest-color match block: registers, palette RAM,
// distance pipeline, best-match tracking and output register.
// Depends on pnc_pkg and pnc_ram.
`default_nettype none

module pnc_dp
  import pnc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pnc_cmd_t               cmd,
  output pnc_stat_t                   stat,
  // input item fields
  input  wire op_t                    op,
  input  wire logic [INDEX_W-1:0]     entry_index,
  input  wire logic [COMP_W-1:0]      red_in,
  input  wire logic [COMP_W-1:0]      green_in,
  input  wire logic [COMP_W-1:0]      blue_in,
  input  wire logic [COLOR_W-1:0]     query_rgb,
  input  wire logic [NATIVE_W-1:0]    native_color,
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // output register
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [OUT_DATA_W-1:0]       out_data
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  // Configuration registers
  logic              enabled;
  logic [DIST_W-1:0] match_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b1;
      match_limit <= MATCH_LIMIT_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE: enabled     <= cfg_data[0];
        REG_LIMIT:  match_limit <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Scan / clear address counter, wraps after the last entry
  logic [AW-1:0] scan_addr;
  logic          scan_last;
  assign scan_last = (scan_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (cmd.clear_wr || cmd.scan_rd) begin
      scan_addr <= scan_last ? '0 : scan_addr + 1'b1;
    end
  end

  // Input decode: write range check and clamped reverse address
  logic          wr_in_range;
  logic [7:0]    rev_k8;
  logic [31:0]   rev_k;
  logic [AW-1:0] rev_addr;

  assign wr_in_range = ({24'd0, entry_index} < 32'(PALETTE_ENTRIES));
  assign rev_k8 = (native_color > NATIVE_W'(REV_CLAMP_INDEX)) ? REV_CLAMP_INDEX
                                                             : native_color[7:0];
  assign rev_k  = ({24'd0, rev_k8} >= 32'(PALETTE_ENTRIES)) ? 32'(PALETTE_ENTRIES - 1)
                                                            : {24'd0, rev_k8};

  logic [CHAN_W-1:0] q_r, q_g, q_b;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rev_addr <= rev_k[AW-1:0];
      q_r      <= query_rgb[23:16];
      q_g      <= query_rgb[15:8];
      q_b      <= query_rgb[7:0];
    end
  end

  // Palette RAM: clearing pass or write item on the write port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  always_comb begin
    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = scan_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.accept && (op == OP_WRITE) && wr_in_range;
      ram_waddr = AW'(entry_index);
      ram_wdata = {red_in[15:8], green_in[15:8], blue_in[15:8]};
    end
  end

  assign ram_raddr = cmd.sel_rev ? rev_addr : scan_addr;

  pnc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage 1: read data valid; square the channel differences
  logic          rd_v;
  logic [AW-1:0] rd_idx;
  logic          sq_v;
  logic [AW-1:0] sq_idx;
  logic [15:0]   sq_r, sq_g, sq_b;
  logic [CHAN_W-1:0] d_r, d_g, d_b;

  always_comb begin
    d_r = (q_r > ram_rdata[23:16]) ? q_r - ram_rdata[23:16] : ram_rdata[23:16] - q_r;
    d_g = (q_g > ram_rdata[15:8])  ? q_g - ram_rdata[15:8]  : ram_rdata[15:8] - q_g;
    d_b = (q_b > ram_rdata[7:0])   ? q_b - ram_rdata[7:0]   : ram_rdata[7:0] - q_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      sq_v <= 1'b0;
    end else begin
      rd_v <= cmd.scan_rd;
      sq_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    sq_idx <= rd_idx;
    sq_r   <= 16'(d_r) * 16'(d_r);
    sq_g   <= 16'(d_g) * 16'(d_g);
    sq_b   <= 16'(d_b) * 16'(d_b);
  end

  // Stage 2: sum and compare against running best; lowest index wins ties
  logic [DIST_W-1:0]  sum_dist;
  logic [DIST_W-1:0]  best;
  logic [INDEX_W-1:0] win;

  assign sum_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (cmd.accept && (op == OP_MATCH)) begin
      best <= match_limit;
      win  <= NO_MATCH_INDEX;
    end else if (sq_v && (sum_dist < best)) begin
      best <= sum_dist;
      win  <= INDEX_W'(sq_idx);
    end
  end

  // Reverse color capture
  logic [COLOR_W-1:0] rev_color;

  always_ff @(posedge clk) begin
    if (cmd.cap_rev) begin
      rev_color <= ram_rdata;
    end
  end

  // Output register
  logic [OUT_DATA_W-1:0] out_sel_data;

  always_comb begin
    case (cmd.out_sel)
      OUT_MATCH: out_sel_data = {{COLOR_W{1'b0}}, win};
      OUT_REV:   out_sel_data = {rev_color, {INDEX_W{1'b0}}};
      default:   out_sel_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_sel_data;
    end
  end

  // Status
  assign stat.scan_last  = scan_last;
  assign stat.pipe_empty = !rd_v && !sq_v;
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.enabled    = enabled;

endmodule

`default_nettype wire

/* hw/rtl/palette_nearest_color_match.sv */
// Top level of the palette nearest-color match block: stream ports, config port,
// controller and datapath. Depends on pnc_pkg, pnc_ctrl, pnc_dp (and pnc_ram).
//
// Keeps a PALETTE_ENTRIES-deep palette of 24-bit colors in one RAM. After reset
// a clearing pass zeroes the RAM, one entry a cycle, so no item is accepted until
// the pass is done; configuration writes are taken at any time. A write item is
// written to the RAM as it is accepted and gives no result. A match item scans
// the RAM one entry per cycle through its single read port into a two-stage
// distance pipeline, which drains before its result is loaded into the output
// register. A reverse item reads its clamped entry and captures its color; a lookup
// with the palette disabled gives an all-zero result. Items are handled one at a
// time; a finished result waits in the output register while the next item is
// accepted, and the block stalls only when a new result is ready while the
// previous one is still untaken.
`default_nettype none

module palette_nearest_color_match
  import pnc_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input items
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // entry_index[7:0], red_in[23:8], green_in[39:24], blue_in[55:40],
  // query_rgb[79:56], native_color[95:80]
  input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser,
  // result items
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // matched_index[7:0], color_rgb[31:8]
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  pnc_cmd_t  cmd;
  pnc_stat_t stat;
  op_t       op;

  assign op        = op_t'(s_axis_tuser);
  assign cfg_ready = 1'b1;

  pnc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .op       (op),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  pnc_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .entry_index  (s_axis_tdata[7:0]),
    .red_in       (s_axis_tdata[23:8]),
    .green_in     (s_axis_tdata[39:24]),
    .blue_in      (s_axis_tdata[55:40]),
    .query_rgb    (s_axis_tdata[79:56]),
    .native_color (s_axis_tdata[95:80]),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_data     (m_axis_tdata)
  );

  // Clearing pass holds off input items right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

  // A result carries either a match index or a color, never both
  a_result_one_field: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:8] == 24'd0 || m_axis_tdata[7:0] == 8'd0))
    else $error("result has both index and color set");

  // A write item finishes in its accept cycle and leaves the block idle
  a_write_single_cycle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_WRITE) |=> s_axis_tready)
    else $error("write item did not complete in one cycle");

endmodule

`default_nettype wire

/* test/palette_nearest_color_match_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for palette_nearest_color_match: palette writes, nearest-color
// matches and reverse lookups under several register settings, each result predicted here.
// Depends on pnc_pkg and the RTL of the block.

module palette_nearest_color_match_test;
  import pnc_pkg::*;

  localparam int ENTRIES = PALETTE_ENTRIES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam logic [DIST_W-1:0] LIMIT_MAX = 18'd195076;
  // every item a full match scan, worst gaps and stalls, then margin
  localparam longint CYCLE_LIMIT = longint'(RANDOM_ITEMS + 100) * (ENTRIES + 13) * 4;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [INDEX_W-1:0]  entry;
    logic [COMP_W-1:0]   red;
    logic [COMP_W-1:0]   green;
    logic [COMP_W-1:0]   blue;
    logic [COLOR_W-1:0]  query;
    logic [NATIVE_W-1:0] native;
  } palette_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
  } lookup_result_t;

  typedef struct packed {
    palette_item_t  item;
    logic           typed;
    lookup_result_t want;
  } directed_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  reg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // predictor state
  logic [COLOR_W-1:0] palette_copy [ENTRIES];
  logic               enabled_copy;
  logic [DIST_W-1:0]  limit_copy;
  lookup_result_t     expected_lookups[$];
  directed_row_t      directed_rows[$];

  logic   no_idle = 1'b0;
  int     items_sent = 0;
  int     lookups_checked = 0;
  int     match_hits = 0;
  int     error_count = 0;
  longint cycle_count = 0;

  palette_nearest_color_match dut (
    .clk,
    .rst,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Squared Euclidean distance between two packed colors
  function automatic int color_distance(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
    int d;
    int sum;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
      sum += d * d;
    end
    return sum;
  endfunction

  // Apply one accepted item to the palette copy; returns 1 when it yields a lookup
  function automatic bit palette_step(palette_item_t it, output lookup_result_t res);
    int best;
    int entry_dist;
    logic [INDEX_W-1:0] slot;
    res = '0;
    case (it.op)
      OP_WRITE: begin
        palette_copy[it.entry] = {it.red[15:8], it.green[15:8], it.blue[15:8]};
        return 1'b0;
      end
      OP_MATCH: begin
        if (enabled_copy) begin
          best = int'(limit_copy);
          res.index = NO_MATCH_INDEX;
          // strict compare keeps the lowest index on a tie
          for (int i = 0; i < ENTRIES; i++) begin
            entry_dist = color_distance(it.query, palette_copy[i]);
            if (entry_dist < best) begin
              best = entry_dist;
              res.index = INDEX_W'(i);
            end
          end
        end
        return 1'b1;
      end
      OP_REVERSE: begin
        slot = (it.native > REV_CLAMP_INDEX) ? REV_CLAMP_INDEX : it.native[INDEX_W-1:0];
        if (enabled_copy) res.color = palette_copy[slot];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Move a channel by a small random amount, held inside 0..255
  function automatic logic [7:0] nudge(logic [7:0] ch);
    int v;
    v = int'($urandom_range(0, 40)) - 20 + int'(ch);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic palette_item_t random_item();
    palette_item_t it;
    logic [COLOR_W-1:0] near;
    int pick;
    it.entry  = INDEX_W'($urandom);
    it.red    = COMP_W'($urandom);
    it.green  = COMP_W'($urandom);
    it.blue   = COMP_W'($urandom);
    it.query  = COLOR_W'($urandom);
    it.native = NATIVE_W'($urandom);
    near = palette_copy[$urandom_range(0, ENTRIES - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.op = OP_WRITE;
      // some writes copy a stored color so that ties come up
      if ($urandom_range(0, 3) == 0) begin
        it.red[15:8]   = near[23:16];
        it.green[15:8] = near[15:8];
        it.blue[15:8]  = near[7:0];
      end
    end else if (pick < 70) begin
      it.op = OP_MATCH;
      // mostly near a stored color so the limit is actually met
      if ($urandom_range(0, 2) != 0)
        it.query = {nudge(near[23:16]), nudge(near[15:8]), nudge(near[7:0])};
    end else if (pick < 95) begin
      it.op = OP_REVERSE;
      if ($urandom_range(0, 1) == 0) it.native = NATIVE_W'($urandom_range(0, ENTRIES - 1));
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, logic [INDEX_W-1:0] entry,
      logic [COMP_W-1:0] red, logic [COMP_W-1:0] green, logic [COMP_W-1:0] blue,
      logic [COLOR_W-1:0] query, logic [NATIVE_W-1:0] native, logic typed = 1'b0,
      logic [INDEX_W-1:0] index = '0, logic [COLOR_W-1:0] color = '0);
    directed_row_t row;
    row.item  = '{op, entry, red, green, blue, query, native};
    row.typed = typed;
    row.want  = '{index, color};
    directed_rows.push_back(row);
  endfunction

  // Present one item after a random gap; predict once it is taken
  task automatic send_item(palette_item_t it, logic typed, lookup_result_t want);
    int gap;
    bit has_res;
    lookup_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {it.native, it.query, it.blue, it.green, it.red, it.entry};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    has_res = palette_step(it, res);
    if (typed) expected_lookups.push_back(want);
    else if (has_res) expected_lookups.push_back(res);
    if (it.op == OP_MATCH && enabled_copy && res.index != NO_MATCH_INDEX) match_hits++;
    items_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_ENABLE) enabled_copy = data[0];
    else limit_copy = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall before each item
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk) begin : result_check
    lookup_result_t want;
    logic [INDEX_W-1:0] got_index;
    logic [COLOR_W-1:0] got_color;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got_index = m_axis_tdata[INDEX_W-1:0];
      got_color = m_axis_tdata[INDEX_W +: COLOR_W];
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d color %06h",
                                  got_index, got_color));
      end else begin
        want = expected_lookups.pop_front();
        lookups_checked++;
        if (got_index !== want.index)
          report_mismatch($sformatf("matched_index %0d, expected %0d", got_index, want.index));
        if (got_color !== want.color)
          report_mismatch($sformatf("color_rgb %06h, expected %06h", got_color, want.color));
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_lookups.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    palette_item_t it;
    lookup_result_t none;
    logic en;
    logic [DIST_W-1:0] lim;
    int sent;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ENABLE;
    cfg_data      = '0;
    none          = '0;
    for (int i = 0; i < ENTRIES; i++) palette_copy[i] = '0;
    enabled_copy = 1'b1;
    limit_copy   = MATCH_LIMIT_RESET;

    // empty palette after reset
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h000000, 16'd0, 1'b1, 8'd0, 24'h000000);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'h000000, 16'd0, 1'b1, 8'd0, 24'h000000);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'hffffff, 16'd0, 1'b1, NO_MATCH_INDEX, 24'h000000);
    // white at the top entry; large reverse indexes clamp onto it
    add_row(OP_WRITE, 8'hff, 16'hffff, 16'hffff, 16'hffff, 24'h0, 16'd0);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'hffff, 1'b1, 8'd0, 24'hffffff);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'h0100, 1'b1, 8'd0, 24'hffffff);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'h00ff, 1'b1, 8'd0, 24'hffffff);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'hffffff, 16'd0, 1'b1, 8'hff, 24'h000000);
    // only the upper byte of each component is stored
    add_row(OP_WRITE, 8'd3, 16'h12ab, 16'h34cd, 16'h56ef, 24'h0, 16'd0);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'd3, 1'b1, 8'd0, 24'h123456);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'h123456, 16'd0);
    // unused code is dropped: entry 0 stays black
    add_row(OP_UNUSED, 8'h00, 16'habcd, 16'hef01, 16'h2345, 24'hffffff, 16'hffff);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'd0, 1'b1, 8'd0, 24'h000000);
    // same color at a higher index: the lower index keeps the tie
    add_row(OP_WRITE, 8'd7, 16'h1200, 16'h3400, 16'h5600, 24'h0, 16'd0);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'h123457, 16'd0);
    // distance equal to the limit misses, one step closer hits
    add_row(OP_WRITE, 8'd128, 16'h80ff, 16'h8000, 16'h8055, 24'h0, 16'd0);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'ha08080, 16'd0);
    add_row(OP_MATCH, 0, 0, 0, 0, 24'h9f8080, 16'd0);
    // alternating bit patterns
    add_row(OP_WRITE, 8'haa, 16'haaaa, 16'h5555, 16'hf0f0, 24'h0, 16'd0);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'h00aa, 1'b0);
    add_row(OP_WRITE, 8'h55, 16'h5555, 16'haaaa, 16'h0f0f, 24'h0, 16'd0);
    add_row(OP_REVERSE, 0, 0, 0, 0, 24'h0, 16'h0055, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // random items under a sweep of register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin en = 1'b1; lim = MATCH_LIMIT_RESET; end
        1: begin en = 1'b1; lim = '0; end
        2: begin en = 1'b0; lim = MATCH_LIMIT_RESET; end
        3: begin en = 1'b1; lim = LIMIT_MAX; end
        4: begin en = 1'b1; lim = DIST_W'($urandom_range(1, 4096)); end
        5: begin en = 1'b1; lim = 18'd1; end
        6: begin en = 1'b0; lim = LIMIT_MAX; end
        default: begin en = 1'b1; lim = DIST_W'($urandom_range(0, LIMIT_MAX)); end
      endcase
      wait_idle();
      // upper data bits are don't-care for the enable register
      write_reg(REG_ENABLE, {(CFG_DATA_W - 1)'($urandom), en});
      write_reg(REG_LIMIT, lim);
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        it = random_item();
        if ($urandom_range(0, 49) == 0) no_idle = ~no_idle;
        send_item(it, 1'b0, none);
        if (it.op != OP_UNUSED) sent++;
      end
    end

    wait_idle();
    $display("%0d items sent, %0d lookup results checked, %0d matches found an entry",
             items_sent, lookups_checked, match_hits);
    $display("%0d register settings, palette on and off, match limit 0 up to %0d",
             PHASES, LIMIT_MAX);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
